// ----- design/mqls_pkg.sv -----
// ----------------------------------------------------------------------------
// mqls_pkg
// Shared types and constants of the multi-queue linked store: field widths,
// action and status codes, and the memory command bundle.
// ----------------------------------------------------------------------------
package mqls_pkg;

    localparam int ACTION_W   = 1;
    localparam int QID_W      = 2;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;

    // tdata widths rounded up to whole bytes
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

// ----- design/multi_queue_linked_store.sv -----
// ----------------------------------------------------------------------------
// multi_queue_linked_store
// QUEUES FIFO queues sharing one store of ENTRIES words, chained by links.
// ----------------------------------------------------------------------------
// Each item on the slave stream enqueues a word onto a queue or dequeues the
// oldest word from it, and yields exactly one result item: status 0 done,
// 1 store full (enqueue ignored), 2 queue empty (data all ones). The block
// takes one item per cycle sustained while the master stream is not stalled;
// each result passes an input and a result register before it is offered
// on the master stream. The rate is set by the pointer update of one item: one
// link read and one link write on the shared link array, with the word store
// read registered into the result. No clearing pass follows reset; a fill
// count tracks the part of the store that still holds its reset free chain.
module multi_queue_linked_store #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[0], queue_id[2:1], data_in[34:3], zero pad
    input  logic [mqls_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], data_out[33:2], zero pad
    output logic [mqls_pkg::M_TDATA_W-1:0]      m_tdata
);
    import mqls_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic                in_valid_reg;
    action_t             in_action_reg;
    logic [QID_W-1:0]    in_qid_reg;
    logic [WORD_W-1:0]   in_data_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_deq_reg;

    logic                s_accept;
    logic                advance;
    status_t             core_status;
    mem_cmd_t            mem_cmd;
    logic [IW-1:0]       mem_addr;
    logic [WORD_W-1:0]   mem_rdata;
    logic [WORD_W-1:0]   data_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= action_t'(s_tdata[0]);
            in_qid_reg    <= s_tdata[2:1];
            in_data_reg   <= s_tdata[34:3];
        end
        if (advance) begin
            out_status_reg <= core_status;
            out_deq_reg    <= (in_action_reg == ACT_DEQ);
        end
    end

    mqls_core #(
        .ENTRIES (ENTRIES),
        .QUEUES  (QUEUES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .action   (in_action_reg),
        .queue_id (in_qid_reg),
        .status   (core_status),
        .cmd      (mem_cmd),
        .addr     (mem_addr)
    );

    mqls_word_mem #(
        .ENTRIES (ENTRIES)
    ) u_word_mem (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (in_data_reg),
        .rdata (mem_rdata)
    );

    always_comb begin
        if (out_status_reg == ST_EMPTY) begin
            data_out = EMPTY_WORD;
        end else if (out_status_reg == ST_DONE && out_deq_reg) begin
            data_out = mem_rdata;
        end else begin
            data_out = '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - WORD_W - STATUS_W)'(0), data_out, out_status_reg};

endmodule

// ----- design/mqls_word_mem.sv -----
// ----------------------------------------------------------------------------
// mqls_word_mem
// Data word store of the shared entries: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mqls_word_mem #(
    parameter int ENTRIES = 16
) (
    input  logic                                aclk,
    input  mqls_pkg::mem_cmd_t                  cmd,
    input  logic [$clog2(ENTRIES)-1:0]          addr,
    input  logic [mqls_pkg::WORD_W-1:0]         wdata,
    output logic [mqls_pkg::WORD_W-1:0]         rdata
);
    import mqls_pkg::*;

    logic [WORD_W-1:0] mem [ENTRIES];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[addr] <= wdata;
        end
        // hold the last read word until the next dequeue
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mqls_core.sv -----
// ----------------------------------------------------------------------------
// mqls_core
// Pointer logic: per-queue head and tail, the free list head, the shared link
// array and a fill count that stands in for the reset chain of the free list.
// ----------------------------------------------------------------------------
module mqls_core #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  mqls_pkg::action_t                   action,
    input  logic [mqls_pkg::QID_W-1:0]          queue_id,
    output mqls_pkg::status_t                   status,
    output mqls_pkg::mem_cmd_t                  cmd,
    output logic [$clog2(ENTRIES)-1:0]          addr
);
    import mqls_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int PW  = IW + 1;
    localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    logic [PW-1:0] head_reg [QUEUES];
    logic [PW-1:0] tail_reg [QUEUES];
    logic [PW-1:0] link_reg [ENTRIES];
    logic [PW-1:0] free_reg;
    logic [PW-1:0] fill_reg;

    logic          q_ok;
    logic [QIW-1:0] q_idx;
    logic [PW-1:0] cur_head;
    logic [PW-1:0] cur_tail;
    logic          head_null;
    logic          free_null;
    logic          is_enq;
    logic          enq_ok;
    logic          deq_ok;
    logic [PW-1:0] slot;
    logic [IW-1:0] slot_idx;
    logic [PW-1:0] link_rd;
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [PW-1:0] link_wdata;

    always_comb begin
        q_ok      = (32'(queue_id) < 32'(QUEUES));
        q_idx     = q_ok ? QIW'(queue_id) : '0;
        cur_head  = head_reg[q_idx];
        cur_tail  = tail_reg[q_idx];
        head_null = (cur_head >= NIL);
        free_null = (free_reg >= NIL);
        is_enq    = (action == ACT_ENQ);
        enq_ok    = is_enq && q_ok && !free_null;
        deq_ok    = !is_enq && q_ok && !head_null;
        slot      = is_enq ? free_reg : cur_head;
        slot_idx  = slot[IW-1:0];
        // entries past the fill count still hold their reset chain link
        link_rd   = (slot >= fill_reg) ? slot + PW'(1) : link_reg[slot_idx];

        if (is_enq) begin
            status = enq_ok ? ST_DONE : ST_FULL;
        end else begin
            status = deq_ok ? ST_DONE : ST_EMPTY;
        end

        cmd.wr = advance && enq_ok;
        cmd.rd = advance && deq_ok;
        addr   = slot_idx;

        // enqueue links behind the tail, dequeue pushes onto the free list
        link_we    = advance && ((enq_ok && !head_null) || deq_ok);
        link_waddr = is_enq ? cur_tail[IW-1:0] : slot_idx;
        link_wdata = is_enq ? slot : free_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            free_reg <= '0;
            fill_reg <= '0;
        end else if (advance) begin
            if (enq_ok) begin
                free_reg <= link_rd;
                if (slot >= fill_reg) begin
                    fill_reg <= fill_reg + PW'(1);
                end
                if (head_null) begin
                    head_reg[q_idx] <= slot;
                end
                tail_reg[q_idx] <= slot;
            end else if (deq_ok) begin
                // the tail's link is never read: the tail itself ends the chain
                if (slot == cur_tail) begin
                    head_reg[q_idx] <= NIL;
                    tail_reg[q_idx] <= NIL;
                end else begin
                    head_reg[q_idx] <= link_rd;
                end
                free_reg <= slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_reg[link_waddr] <= link_wdata;
        end
    end

endmodule

// ----- design/mqls_checker.sv -----
// ----------------------------------------------------------------------------
// mqls_checker
// Port-level checks of the multi-queue linked store result stream.
// ----------------------------------------------------------------------------
module mqls_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mqls_pkg::M_TDATA_W-1:0]      m_tdata
);
    import mqls_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [WORD_W-1:0]   word;

    assign st   = m_tdata[1:0];
    assign word = m_tdata[33:2];

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_EMPTY |-> word == EMPTY_WORD)
        else $error("empty result without all-ones word");

    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_FULL |-> word == '0)
        else $error("full result with nonzero word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind multi_queue_linked_store mqls_checker u_mqls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
